FILE: rtl/altitude_glitch_and_velocity_filter_defines.svh
// assertion helpers used by the checker file
`ifndef ALTITUDE_GLITCH_AND_VELOCITY_FILTER_DEFINES_SVH
`define ALTITUDE_GLITCH_AND_VELOCITY_FILTER_DEFINES_SVH

// property checked outside reset
`define AGVF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also holds while reset is applied
`define AGVF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/agvf_pkg.sv
`default_nettype none

package agvf_pkg;

    localparam int HEIGHT_W   = 24;
    localparam int VEL_IN_W   = 16;
    localparam int VEL_W      = 24;
    localparam int TIME_W     = 32;
    localparam int VZ_W       = 32;
    localparam int GAIN_W     = 9;
    localparam int MODE_W     = 2;
    localparam int FACT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_W      = 48;
    localparam int DEN_W      = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LPF_GAIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ALT     = 2'd2;

    // glitch modes
    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DIVIDE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd2;

    localparam logic [GAIN_W-1:0]   GAIN_RESET    = 9'd77;
    localparam logic [GAIN_W-1:0]   GAIN_FULL     = 9'd256;
    localparam logic [HEIGHT_W-1:0] MIN_ALT_RESET = 24'd15360;
    localparam logic [19:0]         US_PER_S      = 20'd1000000;

    typedef logic [HEIGHT_W-1:0]      height_t;
    typedef logic signed [VEL_W-1:0]  vel_t;
    typedef logic signed [VZ_W-1:0]   vz_t;
    typedef logic [TIME_W-1:0]        time_t;

endpackage

`default_nettype wire

FILE: rtl/altitude_glitch_and_velocity_filter.sv
`default_nettype none

// Altitude glitch and velocity filter. Takes one beat at a time through a
// small sequencer built around a shared restoring divider that resolves one
// quotient bit per cycle over 48 steps. A sonar beat uses one division, for
// the vertical velocity, which is skipped when the height is unchanged or
// the time difference is zero. A flow beat uses one division per filtered
// velocity lane plus the vertical one, which is skipped in the same way, and
// one more when the height is divided by three. in_stall stays high from
// acceptance until the result is loaded into the output register, plus any
// cycles that a stalled earlier result still holds that register; a
// finished result waits there while the next beat is worked on.
// The configuration port is always ready and should be written while idle.
module altitude_glitch_and_velocity_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [agvf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [agvf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              operation,
    input  wire logic [agvf_pkg::HEIGHT_W-1:0]     height_in,
    input  wire logic signed [agvf_pkg::VEL_IN_W-1:0] vel_x_in,
    input  wire logic signed [agvf_pkg::VEL_IN_W-1:0] vel_y_in,
    input  wire logic [agvf_pkg::TIME_W-1:0]       time_us,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [agvf_pkg::HEIGHT_W-1:0]          height_out,
    output logic signed [agvf_pkg::VEL_W-1:0]      vel_x_out,
    output logic signed [agvf_pkg::VEL_W-1:0]      vel_y_out,
    output logic signed [agvf_pkg::VZ_W-1:0]       vel_z_out,
    output logic [agvf_pkg::FACT_W-1:0]            jump_factor
);
    import agvf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GLITCH = 4'd1;
    localparam logic [3:0] S_DIVM   = 4'd2;
    localparam logic [3:0] S_POSTM  = 4'd3;
    localparam logic [3:0] S_MULA   = 4'd4;
    localparam logic [3:0] S_MULB   = 4'd5;
    localparam logic [3:0] S_LOADV  = 4'd6;
    localparam logic [3:0] S_DIVV   = 4'd7;
    localparam logic [3:0] S_POSTV  = 4'd8;
    localparam logic [3:0] S_VZ     = 4'd9;
    localparam logic [3:0] S_LOADZ  = 4'd10;
    localparam logic [3:0] S_DIVZ   = 4'd11;
    localparam logic [3:0] S_POSTZ  = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    localparam logic [5:0] DIV_LAST = 6'(DIV_W - 1);

    logic [3:0]                 state_reg, state_next;
    logic [GAIN_W-1:0]          gain_reg, gain_next;
    logic [MODE_W-1:0]          mode_reg, mode_next;
    height_t                    min_alt_reg, min_alt_next;
    logic                       op_reg, op_next;
    height_t                    m_reg, m_next;
    logic signed [VEL_IN_W-1:0] vx_in_reg, vx_in_next, vy_in_reg, vy_in_next;
    time_t                      t_reg, t_next;
    logic [FACT_W-1:0]          f_reg, f_next;
    height_t                    last_good_reg, last_good_next;
    height_t                    height_reg, height_next;
    vel_t                       filt_x_reg, filt_x_next, filt_y_reg, filt_y_next;
    height_t                    prior_h_reg, prior_h_next, older_h_reg, older_h_next;
    time_t                      prior_t_reg, prior_t_next, older_t_reg, older_t_next;
    vz_t                        vz_reg, vz_next;
    logic                       first_reg, first_next;
    logic                       sel_y_reg, sel_y_next;
    logic signed [33:0]         prod_reg, prod_next;
    logic signed [39:0]         acc_reg, acc_next;
    logic                       neg_reg, neg_next;
    logic signed [DIV_W-1:0]    vzp_reg, vzp_next;
    logic [DIV_W-1:0]           quo_reg, quo_next;
    logic [DEN_W-1:0]           rem_reg, rem_next, den_reg, den_next;
    logic [5:0]                 cnt_reg, cnt_next;
    logic                       ov_reg, ov_next;
    height_t                    ho_reg, ho_next;
    vel_t                       vxo_reg, vxo_next, vyo_reg, vyo_next;
    vz_t                        vzo_reg, vzo_next;
    logic [FACT_W-1:0]          jf_reg, jf_next;

    // combinational helpers
    logic [GAIN_W-1:0]          g_eff, g_inv;
    logic [27:0]                m4, l15;
    logic [26:0]                m2, l5, m4s, l7;
    logic                       above, jump4, jump3, jump2;
    logic [DEN_W:0]             rem_sh;
    logic                       ge;
    logic signed [39:0]         pf, gv;
    logic signed [VEL_IN_W-1:0] vel_sel;
    logic [DIV_W-1:0]           acc_ext, den_ext;
    logic [DEN_W-1:0]           den_v;
    logic [VEL_W-1:0]           qv;
    logic signed [24:0]         diff;
    time_t                      dt;

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign height_out  = ho_reg;
    assign vel_x_out   = vxo_reg;
    assign vel_y_out   = vyo_reg;
    assign vel_z_out   = vzo_reg;
    assign jump_factor = jf_reg;

    // gain clamp and jump thresholds
    always_comb
    begin
        g_eff = (gain_reg > GAIN_FULL) ? GAIN_FULL : gain_reg;
        g_inv = GAIN_FULL - g_eff;
        m4    = {2'b00, m_reg, 2'b00};
        l15   = ({last_good_reg, 4'b0000}) - {4'b0000, last_good_reg};
        m2    = {2'b00, m_reg, 1'b0};
        l5    = {1'b0, last_good_reg, 2'b00} + {3'b000, last_good_reg};
        m4s   = {1'b0, m_reg, 2'b00};
        l7    = {last_good_reg, 3'b000} - {3'b000, last_good_reg};
        above = (m_reg >= min_alt_reg);
        jump4 = (m4 > l15);
        jump3 = (m2 > l5);
        jump2 = (m4s > l7);
    end

    // divider step, filter products and vertical difference
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[DIV_W-1]};
        ge      = (rem_sh >= {1'b0, den_reg});
        vel_sel = sel_y_reg ? vy_in_reg : vx_in_reg;
        pf      = prod_reg * $signed({1'b0, f_reg});
        gv      = $signed({1'b0, g_eff}) * vel_sel;
        den_v   = {21'd0, f_reg, 8'd0};
        acc_ext = {{(DIV_W-40){acc_reg[39]}}, acc_reg};
        den_ext = {16'd0, den_v};
        qv      = quo_reg[VEL_W-1:0];
        diff    = $signed({1'b0, height_reg}) - $signed({1'b0, older_h_reg});
        dt      = t_reg - older_t_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        gain_next      = gain_reg;
        mode_next      = mode_reg;
        min_alt_next   = min_alt_reg;
        op_next        = op_reg;
        m_next         = m_reg;
        vx_in_next     = vx_in_reg;
        vy_in_next     = vy_in_reg;
        t_next         = t_reg;
        f_next         = f_reg;
        last_good_next = last_good_reg;
        height_next    = height_reg;
        filt_x_next    = filt_x_reg;
        filt_y_next    = filt_y_reg;
        prior_h_next   = prior_h_reg;
        older_h_next   = older_h_reg;
        prior_t_next   = prior_t_reg;
        older_t_next   = older_t_reg;
        vz_next        = vz_reg;
        first_next     = first_reg;
        sel_y_next     = sel_y_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        vzp_next       = vzp_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        ov_next        = ov_reg;
        ho_next        = ho_reg;
        vxo_next       = vxo_reg;
        vyo_next       = vyo_reg;
        vzo_next       = vzo_reg;
        jf_next        = jf_reg;

        // output register drains
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LPF_GAIN:    gain_next    = cfg_data[GAIN_W-1:0];
                CFG_GLITCH_MODE: mode_next    = cfg_data[MODE_W-1:0];
                CFG_MIN_ALT:     min_alt_next = cfg_data[HEIGHT_W-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    m_next     = height_in;
                    vx_in_next = vel_x_in;
                    vy_in_next = vel_y_in;
                    t_next     = time_us;
                    state_next = S_GLITCH;
                end
            end

            S_GLITCH:
            begin
                f_next      = 3'd1;
                height_next = m_reg;
                sel_y_next  = 1'b0;
                if (op_reg)
                begin
                    state_next = S_VZ;
                end
                else
                begin
                    state_next = S_MULA;
                    if (!above)
                    begin
                        last_good_next = m_reg;
                    end
                    else if (mode_reg == MODE_DIVIDE)
                    begin
                        priority if (jump4)
                        begin
                            f_next      = 3'd4;
                            height_next = {2'b00, m_reg[HEIGHT_W-1:2]};
                        end
                        else if (jump3)
                        begin
                            f_next     = 3'd3;
                            quo_next   = {{(DIV_W-HEIGHT_W){1'b0}}, m_reg};
                            rem_next   = '0;
                            den_next   = 32'd3;
                            cnt_next   = '0;
                            state_next = S_DIVM;
                        end
                        else if (jump2)
                        begin
                            f_next      = 3'd2;
                            height_next = {1'b0, m_reg[HEIGHT_W-1:1]};
                        end
                        else
                        begin
                            last_good_next = m_reg;
                        end
                    end
                    else if (mode_reg == MODE_HOLD)
                    begin
                        if (jump2)
                        begin
                            last_good_next = m_reg;
                            height_next    = height_reg;
                        end
                    end
                end
            end

            S_DIVM, S_DIVV, S_DIVZ:
            begin
                rem_next = ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    unique case (state_reg)
                        S_DIVM:  state_next = S_POSTM;
                        S_DIVV:  state_next = S_POSTV;
                        default: state_next = S_POSTZ;
                    endcase
                end
            end

            S_POSTM:
            begin
                height_next = quo_reg[HEIGHT_W-1:0];
                state_next  = S_MULA;
            end

            S_MULA:
            begin
                prod_next  = $signed({1'b0, g_inv}) * (sel_y_reg ? filt_y_reg : filt_x_reg);
                state_next = S_MULB;
            end

            S_MULB:
            begin
                acc_next   = pf + (gv <<< 8);
                state_next = S_LOADV;
            end

            S_LOADV:
            begin
                // floor division of a negative value through its magnitude
                neg_next   = acc_reg[39];
                quo_next   = acc_reg[39] ? (DIV_W'(0) - acc_ext) + den_ext - DIV_W'(1)
                                         : acc_ext;
                rem_next   = '0;
                den_next   = den_v;
                cnt_next   = '0;
                state_next = S_DIVV;
            end

            S_POSTV:
            begin
                if (sel_y_reg)
                begin
                    filt_y_next = neg_reg ? $signed(VEL_W'(0) - qv) : $signed(qv);
                    sel_y_next  = 1'b0;
                    state_next  = S_VZ;
                end
                else
                begin
                    filt_x_next = neg_reg ? $signed(VEL_W'(0) - qv) : $signed(qv);
                    sel_y_next  = 1'b1;
                    state_next  = S_MULA;
                end
            end

            S_VZ:
            begin
                state_next = S_OUT;
                if (first_reg)
                begin
                    prior_h_next = height_reg;
                    older_h_next = height_reg;
                    prior_t_next = t_reg;
                    older_t_next = t_reg;
                    vz_next      = '0;
                    first_next   = 1'b0;
                end
                else if (prior_h_reg != height_reg)
                begin
                    vzp_next     = diff * $signed({1'b0, US_PER_S});
                    den_next     = dt;
                    older_h_next = prior_h_reg;
                    older_t_next = prior_t_reg;
                    prior_h_next = height_reg;
                    prior_t_next = t_reg;
                    if (dt != '0)
                    begin
                        state_next = S_LOADZ;
                    end
                end
            end

            S_LOADZ:
            begin
                neg_next   = vzp_reg[DIV_W-1];
                quo_next   = vzp_reg[DIV_W-1] ? DIV_W'(DIV_W'(0) - vzp_reg) : vzp_reg;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIVZ;
            end

            S_POSTZ:
            begin
                // truncate toward zero then saturate
                if (!neg_reg)
                begin
                    vz_next = (|quo_reg[DIV_W-1:VZ_W-1]) ? 32'sh7FFF_FFFF
                                                         : $signed(quo_reg[VZ_W-1:0]);
                end
                else
                begin
                    vz_next = (quo_reg > DIV_W'(32'h8000_0000)) ? 32'sh8000_0000
                              : $signed(VZ_W'(0) - quo_reg[VZ_W-1:0]);
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    ho_next    = height_reg;
                    vxo_next   = filt_x_reg;
                    vyo_next   = filt_y_reg;
                    vzo_next   = vz_reg;
                    jf_next    = f_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_reg      <= GAIN_RESET;
            mode_reg      <= MODE_DIVIDE;
            min_alt_reg   <= MIN_ALT_RESET;
            last_good_reg <= '0;
            height_reg    <= '0;
            filt_x_reg    <= '0;
            filt_y_reg    <= '0;
            prior_h_reg   <= '0;
            older_h_reg   <= '0;
            prior_t_reg   <= '0;
            older_t_reg   <= '0;
            vz_reg        <= '0;
            first_reg     <= 1'b1;
            sel_y_reg     <= 1'b0;
            cnt_reg       <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_reg      <= gain_next;
            mode_reg      <= mode_next;
            min_alt_reg   <= min_alt_next;
            last_good_reg <= last_good_next;
            height_reg    <= height_next;
            filt_x_reg    <= filt_x_next;
            filt_y_reg    <= filt_y_next;
            prior_h_reg   <= prior_h_next;
            older_h_reg   <= older_h_next;
            prior_t_reg   <= prior_t_next;
            older_t_reg   <= older_t_next;
            vz_reg        <= vz_next;
            first_reg     <= first_next;
            sel_y_reg     <= sel_y_next;
            cnt_reg       <= cnt_next;
            ov_reg        <= ov_next;
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        m_reg     <= m_next;
        vx_in_reg <= vx_in_next;
        vy_in_reg <= vy_in_next;
        t_reg     <= t_next;
        f_reg     <= f_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        neg_reg   <= neg_next;
        vzp_reg   <= vzp_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        ho_reg    <= ho_next;
        vxo_reg   <= vxo_next;
        vyo_reg   <= vyo_next;
        vzo_reg   <= vzo_next;
        jf_reg    <= jf_next;
    end

endmodule

`default_nettype wire

FILE: rtl/agvf_checker.sv
`default_nettype none

`include "altitude_glitch_and_velocity_filter_defines.svh"

module agvf_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_stall,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [agvf_pkg::HEIGHT_W-1:0]    height_out,
    input wire logic [agvf_pkg::FACT_W-1:0]      jump_factor
);

    // stalled result beat stays
    `AGVF_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")
    `AGVF_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(height_out), "stalled height moved")

    // one beat in flight at a time
    `AGVF_ASSERT(a_busy, in_valid && !in_stall |=> in_stall, "second beat taken while busy")

    // divisor always one to four
    `AGVF_ASSERT_ALWAYS(a_factor, out_valid |-> jump_factor != 3'd0 && jump_factor <= 3'd4, "bad jump factor")

endmodule

bind altitude_glitch_and_velocity_filter agvf_checker u_agvf_checker (.*);

`default_nettype wire
